[src/sorted_integer_set_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted integer set.
// Both forms are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SORTED_INTEGER_SET_MACROS_SVH
`define SORTED_INTEGER_SET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sorted_integer_set: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sorted_integer_set: next-cycle check failed");

`endif

[src/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and codes for the sorted integer set.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int CAPACITY_DEF = 64;

  // Request codes. Code 3 is unused and acts as a query.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
    logic load;
  } sis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       full;
  } sis_stat_t;

endpackage

`default_nettype wire

[src/sis_if.sv]
// ----------------------------------------------------------------------------
// sis_req_if / sis_rsp_if
// Request and response channels of the sorted integer set.
// ----------------------------------------------------------------------------
`default_nettype none

interface sis_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sis_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [6:0] count;

  modport source (output valid, output status, output found, output count, input ready);
  modport sink   (input valid, input status, input found, input count, output ready);
endinterface

`default_nettype wire

[src/sis_ctrl.sv]
// ----------------------------------------------------------------------------
// sis_ctrl
// Controller: sequences the compare and update steps of each item and holds
// the handshake state of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sis_pkg::sis_stat_t stat,
  output sis_pkg::sis_cmd_t      cmd
);
  import sis_pkg::*;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   exec_go;

  // The update waits while an earlier result is still held at the output.
  assign exec_go = (state == EXEC) && (!out_valid || out_ready);

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.load    = exec_go;
    cmd.insert  = exec_go && (stat.op == REQ_INSERT) && !stat.hit && !stat.full;
    cmd.remove  = exec_go && (stat.op == REQ_REMOVE) && stat.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            state    <= EXEC;
            in_ready <= 1'b0;
          end
        end
        EXEC: begin
          if (exec_go) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/sis_dpath.sv]
// ----------------------------------------------------------------------------
// sis_dpath
// Datapath: a row of entry cells that compare against the request in
// parallel and shift one place up or down, plus the entry count and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_dpath #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sis_pkg::sis_cmd_t  cmd,
  output sis_pkg::sis_stat_t      stat,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] value,
  output logic [1:0]              status,
  output logic                    found,
  output logic [6:0]              count
);
  import sis_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [31:0] store [CAPACITY];
  logic signed [31:0] below_val [CAPACITY];
  logic signed [31:0] above_val [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] prev_lt;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic [CNT_W+6:0]    cnt_ext;
  logic signed [31:0]  v_reg;
  logic [1:0]          op;
  logic                hit;
  logic                full;
  logic [1:0]          status_next;

  // Neighbor wiring of the cell row.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign below_val[g] = v_reg;
        assign prev_lt[g]   = 1'b1;
      end else begin : g_rest
        assign below_val[g] = store[g-1];
        assign prev_lt[g]   = lt[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign above_val[g] = store[g];
      end else begin : g_inner
        assign above_val[g] = store[g+1];
      end
    end
  endgenerate

  assign hit  = |eq;
  assign full = (cnt == CNT_W'(CAPACITY));

  assign stat.op   = op;
  assign stat.hit  = hit;
  assign stat.full = full;

  always_comb begin
    case (op)
      REQ_INSERT: status_next = hit ? ST_PRESENT : (full ? ST_FULL : ST_OK);
      REQ_REMOVE: status_next = hit ? ST_OK : ST_ABSENT;
      default:    status_next = hit ? ST_OK : ST_ABSENT;
    endcase
    if (cmd.insert) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (cmd.remove) begin
      cnt_next = cnt - CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  assign cnt_ext = {7'd0, cnt_next};

  // Compare flags are taken when the item is accepted; entries at or above the
  // count never match. Valid entries are sorted, so the less-than flags form
  // a prefix that ends at the insert or remove position.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_reg <= value;
      op    <= req_type;
      for (int i = 0; i < CAPACITY; i++) begin
        lt[i] <= (CNT_W'(i) < cnt) && (store[i] < value);
        eq[i] <= (CNT_W'(i) < cnt) && (store[i] == value);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.insert) begin
        if (!prev_lt[i]) begin
          store[i] <= below_val[i];
        end else if (!lt[i]) begin
          store[i] <= v_reg;
        end
      end else if (cmd.remove && !lt[i]) begin
        store[i] <= above_val[i];
      end
    end
    if (cmd.load) begin
      status <= status_next;
      found  <= hit;
      count  <= cnt_ext[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

[src/sorted_integer_set.sv]
// ----------------------------------------------------------------------------
// sorted_integer_set
// A set of distinct signed 32-bit integers kept in ascending order.
//
// Requests arrive on the req channel (req_type, value) and each produces one
// item on the rsp channel (status, found, count). Both channels move an item
// when valid and ready are high at a rising clock edge.
// Each item runs a compare step and an update step: the edge that accepts it
// also registers the compare flags of every entry cell, and a later edge,
// once any earlier result held at rsp is taken, applies the one-place shift of
// the cell row and loads the result register. A new request is taken only
// after the compare and update sequence of the previous one is done.
// req.ready is low from the accepting edge until the update is done.
// If rsp stalls while a result is held, the update of the next item waits
// until that result is taken; the set is not touched meanwhile.
// Reset empties the set at once; entry contents need no clearing since only
// entries below the count are ever compared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_integer_set_macros.svh"

module sorted_integer_set #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sis_req_if.sink   req,
  sis_rsp_if.source rsp
);
  import sis_pkg::*;

  sis_cmd_t  cmd;
  sis_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  logic [1:0] rsp_status;
  logic       rsp_found;
  logic [6:0] rsp_count;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sis_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_type (req.req_type),
    .value    (req.value),
    .status   (rsp_status),
    .found    (rsp_found),
    .count    (rsp_count)
  );

  assign req.ready  = in_ready;
  assign rsp.valid  = out_valid;
  assign rsp.status = rsp_status;
  assign rsp.found  = rsp_found;
  assign rsp.count  = rsp_count;

  `SIS_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `SIS_ASSERT_NOW(a_rsp_from_load, clk, rst, $rose(rsp.valid), $past(cmd.load))
  `SIS_ASSERT_NOW(a_insert_has_room, clk, rst, cmd.insert, !stat.full && !stat.hit && !cmd.remove)
  `SIS_ASSERT_NOW(a_present_found, clk, rst, rsp.valid && rsp.status == ST_PRESENT, rsp.found)

endmodule

`default_nettype wire

[tb/sv/sis_set_checker.sv]
// ----------------------------------------------------------------------------
// sis_set_checker
// Watches the request and response channels of the sorted integer set,
// keeps its own copy of the set and checks every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_set_checker #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sis_req_if       req,
  sis_rsp_if       rsp,
  output int       fail_count,
  output int       pending
);
  import sis_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [6:0] count;
  } set_result_t;

  logic signed [31:0] members [CAPACITY];
  int unsigned        member_count;
  set_result_t        awaited_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
    member_count = 0;
  end

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic apply_request(input logic [1:0] op, input logic signed [31:0] v,
                               output set_result_t res);
    int unsigned slot;
    bit          hit;
    slot = 0;
    while (slot < member_count && members[slot] < v) slot++;
    hit = (slot < member_count) && (members[slot] == v);
    res.found = hit;
    if (op == REQ_INSERT) begin
      if (hit) begin
        res.status = ST_PRESENT;
      end else if (member_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int k = member_count; k > slot; k--) members[k] = members[k - 1];
        members[slot] = v;
        member_count++;
        res.status = ST_OK;
      end
    end else if (op == REQ_REMOVE) begin
      if (hit) begin
        for (int k = slot; k + 1 < member_count; k++) members[k] = members[k + 1];
        member_count--;
        res.status = ST_OK;
      end else begin
        res.status = ST_ABSENT;
      end
    end else begin
      // Queries and the unused code leave the set alone.
      res.status = hit ? ST_OK : ST_ABSENT;
    end
    res.count = member_count[6:0];
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      member_count = 0;
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf(
            "response with no request waiting: status %0d found %0d count %0d",
            rsp.status, rsp.found, rsp.count));
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found %0d, expected %0d", rsp.found, want.found));
          if (rsp.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp.count, want.count));
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.value, want);
        awaited_results.push_back(want);
      end
    end
    pending = awaited_results.size();
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted integer set: a directed pass over the extremes and
// special cases, then random fill, mix and drain sequences under three
// idling profiles and one long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sis_pkg::*;

  localparam logic [1:0]         REQ_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX    = 32'sh7FFF_FFFF;
  localparam int                 POOL_SIZE  = 80;
  localparam int                 EPISODE_LEN = 104;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   long_hold;

  // Values are drawn mostly from this pool so that hits, a full store and an
  // empty store all come up often.
  logic signed [31:0] value_pool [POOL_SIZE];

  sis_req_if req_ch ();
  sis_rsp_if rsp_ch ();

  sorted_integer_set dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sis_set_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sorted_integer_set verification failed");
    $finish;
  end

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    if ($urandom_range(99) < 85) begin
      v = value_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      v = $urandom;
      value_pool[$urandom_range(POOL_SIZE - 1)] = v;
    end
    return v;
  endfunction

  function automatic logic [1:0] pick_op(input int insert_pct, input int remove_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct) return REQ_INSERT;
    if (r < insert_pct + remove_pct) return REQ_REMOVE;
    if (r < 95) return REQ_QUERY;
    return REQ_UNUSED;
  endfunction

  initial begin
    int insert_pct;
    int remove_pct;
    int guard;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_QUERY;
    req_ch.value = '0;
    long_hold = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 78;
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0: value_pool[i] = int'($urandom_range(80)) - 40;
        1: value_pool[i] = (i % 8 == 1) ? VAL_MIN + int'($urandom_range(3))
                                        : VAL_MAX - int'($urandom_range(3));
        default: value_pool[i] = $urandom;
      endcase
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set, extremes, duplicates, removal at both ends and
    // in the middle, and the unused request code.
    send_request(REQ_QUERY, 0);
    send_request(REQ_REMOVE, 5);
    send_request(REQ_UNUSED, VAL_MIN);
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, 1);
    send_request(REQ_INSERT, 0);
    send_request(REQ_QUERY, VAL_MIN);
    send_request(REQ_QUERY, VAL_MAX);
    send_request(REQ_QUERY, 2);
    send_request(REQ_UNUSED, -1);
    send_request(REQ_REMOVE, 7);
    send_request(REQ_REMOVE, VAL_MIN);
    send_request(REQ_REMOVE, VAL_MAX);
    send_request(REQ_REMOVE, 0);
    send_request(REQ_INSERT, VAL_MIN + 1);
    send_request(REQ_REMOVE, -1);
    send_request(REQ_REMOVE, 1);
    send_request(REQ_REMOVE, VAL_MIN + 1);
    send_request(REQ_INSERT, VAL_MAX);

    // Random: each idling profile runs fill, mix, fill-to-full and drain.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 12; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 12; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_hold = 1'b1;
        end
      endcase
      for (int ep = 0; ep < 4; ep++) begin
        case (ep)
          0: begin insert_pct = 70; remove_pct = 10; end
          1: begin insert_pct = 35; remove_pct = 35; end
          2: begin insert_pct = 75; remove_pct = 5; end
          default: begin insert_pct = 5; remove_pct = 75; end
        endcase
        for (int n = 0; n < EPISODE_LEN; n++) begin
          send_request(pick_op(insert_pct, remove_pct), pick_value());
        end
      end
    end
    req_ch.valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending != 0) $display("ERROR: %0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_integer_set verification clean");
    end else begin
      $display("sorted_integer_set verification failed");
    end
    $finish;
  end

endmodule
